// ----- hw/rtl/ppp_pkg.sv -----
package ppp_pkg;

  // Fixed-point widths of the datapath.
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int ENTRY_W  = 20;
  localparam int ROW_W    = 3 * ENTRY_W;
  localparam int PROD_W   = DIFF_W + ENTRY_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int MAG_W    = SUM_W;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = 32;
  localparam int REM_W    = MAG_W + 1;
  localparam int DIV_STEPS = QUO_W;
  // Divider pipeline: input register, one register per quotient bit, output register.
  localparam int DIV_LAT  = DIV_STEPS + 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROW_ZERO = 3'd0;
  localparam logic [2:0] CFG_ROW_ONE  = 3'd1;
  localparam logic [2:0] CFG_ROW_TWO  = 3'd2;
  localparam logic [2:0] CFG_CENTER_X = 3'd3;
  localparam logic [2:0] CFG_CENTER_Y = 3'd4;
  localparam logic [2:0] CFG_CENTER_Z = 3'd5;

  // Saturation limits in Q16.16.
  localparam logic [QUO_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] Q_MIN = 32'h8000_0000;

  // Camera set-up as held in the configuration registers.
  typedef struct packed {
    logic [ROW_W-1:0]          row_zero;
    logic [ROW_W-1:0]          row_one;
    logic [ROW_W-1:0]          row_two;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
  } cfg_t;

  // One classified point waiting for division.
  typedef struct packed {
    logic             visible;
    logic [MAG_W-1:0] den;
    logic [MAG_W-1:0] u_mag;
    logic             u_neg;
    logic [MAG_W-1:0] v_mag;
    logic             v_neg;
  } entry_t;

endpackage

// ----- hw/rtl/ppp_front.sv -----
module ppp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  ppp_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic signed [31:0]            px,
  input  logic signed [31:0]            py,
  input  logic signed [31:0]            pz,
  input  logic                          adv,
  output logic                          out_valid,
  output ppp_pkg::entry_t               out_entry
);
  import ppp_pkg::*;

  logic                      v1, v2, v3;
  logic signed [DIFF_W-1:0]  d [3];
  logic signed [ENTRY_W-1:0] m [3][3];
  logic signed [PROD_W-1:0]  p [3][3];
  logic signed [SUM_W-1:0]   q [3];
  logic [ROW_W-1:0]          rows [3];

  assign rows[0] = cfg.row_zero;
  assign rows[1] = cfg.row_one;
  assign rows[2] = cfg.row_two;

  // Unpack the matrix entries; entry c multiplies difference component c.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r][c] = $signed(rows[r][ENTRY_W*c +: ENTRY_W]);
      end
    end
  end

  // Valid bits move only when the queue can take the point at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage one: offset from the camera center, exact in 33 bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      d[0] <= DIFF_W'(px) - DIFF_W'(cfg.center_x);
      d[1] <= DIFF_W'(py) - DIFF_W'(cfg.center_y);
      d[2] <= DIFF_W'(pz) - DIFF_W'(cfg.center_z);
    end
  end

  // Stage two: the nine matrix products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r][c] <= PROD_W'(m[r][c]) * PROD_W'(d[c]);
        end
      end
    end
  end

  // Stage three: row sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        q[r] <= SUM_W'(p[r][0]) + SUM_W'(p[r][1]) + SUM_W'(p[r][2]);
      end
    end
  end

  // Classify: depth sign decides visibility, numerators split into sign and magnitude.
  always_comb begin
    out_entry.visible = ~q[2][SUM_W-1];
    out_entry.den     = MAG_W'(q[2]);
    out_entry.u_neg   = q[0][SUM_W-1];
    out_entry.u_mag   = q[0][SUM_W-1] ? MAG_W'(-q[0]) : MAG_W'(q[0]);
    out_entry.v_neg   = q[1][SUM_W-1];
    out_entry.v_mag   = q[1][SUM_W-1] ? MAG_W'(-q[1]) : MAG_W'(q[1]);
  end

  assign out_valid = v3;

endmodule

// ----- hw/rtl/ppp_queue.sv -----
module ppp_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppp_pkg::entry_t push_data,
  input  logic            pop,
  output ppp_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import ppp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign empty   = (count == CNT_W'(0));
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr];

  // Storage for the waiting beats.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ppp_div.sv -----
module ppp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ppp_pkg::MAG_W-1:0]   in_mag,
  input  logic                        in_neg,
  input  logic [ppp_pkg::MAG_W-1:0]   in_den,
  output logic                        out_valid,
  output logic [ppp_pkg::QUO_W-1:0]   out_quo
);
  import ppp_pkg::*;

  logic             v   [DIV_STEPS+1];
  logic [REM_W-1:0] rem [DIV_STEPS+1];
  logic [QUO_W-1:0] lo  [DIV_STEPS+1];
  logic [QUO_W-1:0] quo [DIV_STEPS+1];
  logic [MAG_W-1:0] den [DIV_STEPS+1];
  logic             neg [DIV_STEPS+1];
  logic             sat [DIV_STEPS+1];
  logic             zr  [DIV_STEPS+1];
  logic             ovf;
  logic [QUO_W-1:0] res;

  // The quotient overflows 32 bits when mag >= den * 2^16 (always true for a zero divisor).
  assign ovf = {{FRAC_W{1'b0}}, in_mag} >= {in_den, {FRAC_W{1'b0}}};

  // Entry register: integer part of the numerator seeds the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= REM_W'(in_mag >> FRAC_W);
    lo[0]  <= {in_mag[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
    quo[0] <= '0;
    den[0] <= in_den;
    neg[0] <= in_neg;
    zr[0]  <= (in_mag == '0);
    sat[0] <= ovf;
  end

  // One restoring step per stage, one quotient bit each.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = {rem[k-1][REM_W-2:0], lo[k-1][QUO_W-1]};
    assign ge    = trial >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? trial - {1'b0, den[k-1]} : trial;
      lo[k]  <= {lo[k-1][QUO_W-2:0], 1'b0};
      quo[k] <= {quo[k-1][QUO_W-2:0], ge};
      den[k] <= den[k-1];
      neg[k] <= neg[k-1];
      sat[k] <= sat[k-1];
      zr[k]  <= zr[k-1];
    end
  end

  assign res = quo[DIV_STEPS];

  // Apply the sign and saturate to the signed 32-bit range.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (zr[DIV_STEPS]) begin
      out_quo <= '0;
    end else if (!neg[DIV_STEPS]) begin
      out_quo <= (sat[DIV_STEPS] || res[QUO_W-1]) ? Q_MAX : res;
    end else begin
      out_quo <= (sat[DIV_STEPS] || (res[QUO_W-1] && (|res[QUO_W-2:0]))) ? Q_MIN : -res;
    end
  end

endmodule

// ----- hw/rtl/ppp_back.sv -----
module ppp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  ppp_pkg::entry_t        in_entry,
  output logic                   pop,
  output logic                   done,
  output logic                   visible,
  output logic signed [31:0]     image_u,
  output logic signed [31:0]     image_v,
  output logic signed [31:0]     inverse_depth
);
  import ppp_pkg::*;

  localparam logic [MAG_W-1:0] ONE_Q32 = MAG_W'(1) << (2 * FRAC_W);

  logic             vis_d [DIV_LAT];
  logic             u_valid, v_valid, id_valid;
  logic [QUO_W-1:0] u_quo, v_quo, id_quo;

  // The dividers never stall, so a waiting beat is taken every cycle.
  assign pop = in_valid;

  ppp_div u_div_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mag    (in_entry.u_mag),
    .in_neg    (in_entry.u_neg),
    .in_den    (in_entry.den),
    .out_valid (u_valid),
    .out_quo   (u_quo)
  );

  ppp_div u_div_v (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mag    (in_entry.v_mag),
    .in_neg    (in_entry.v_neg),
    .in_den    (in_entry.den),
    .out_valid (v_valid),
    .out_quo   (v_quo)
  );

  ppp_div u_div_id (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mag    (ONE_Q32),
    .in_neg    (1'b0),
    .in_den    (in_entry.den),
    .out_valid (id_valid),
    .out_quo   (id_quo)
  );

  // Visibility rides alongside the dividers.
  always_ff @(posedge clk) begin
    vis_d[0] <= in_entry.visible;
    for (int i = 1; i < DIV_LAT; i++) begin
      vis_d[i] <= vis_d[i-1];
    end
  end

  // Result register; a point behind the camera gets the fixed invisible values.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= u_valid & v_valid & id_valid;
    end
  end

  always_ff @(posedge clk) begin
    visible <= vis_d[DIV_LAT-1];
    if (vis_d[DIV_LAT-1]) begin
      image_u       <= $signed(u_quo);
      image_v       <= $signed(v_quo);
      inverse_depth <= $signed(id_quo);
    end else begin
      image_u       <= $signed(Q_MAX);
      image_v       <= '0;
      inverse_depth <= '0;
    end
  end

endmodule

// ----- hw/rtl/perspective_point_projection.sv -----
// Perspective projection of one world point per beat through a pinhole camera.
// Input channel: a point (point_x, point_y, point_z, signed Q16.16) is taken at a
// rising edge with start high and busy low. Result channel: done is high for
// exactly one cycle with visible, image_u, image_v and inverse_depth (Q16.16);
// the receiver cannot stall, so results never back up.
// Configuration: cfg_valid with cfg_index and cfg_data writes one register
// (three packed matrix rows, then center x, y, z); cfg_ready is always high.
// Write configuration only while no point is in flight.
// From the accepting edge, a point passes three front stages
// (offset, products, row sums), one queue slot, and the divider pipeline
// that retires one quotient bit per stage, then the result register sets done.
// Throughput: one point per cycle while busy is low; every stage, including each
// bit step of the three dividers, holds its own point.
// Reset clears the configuration registers to zero and empties the pipeline
// and queue; datapath registers are left as they are.
// busy rises only when the queue between front and back is full.
module perspective_point_projection #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data,
  output logic               done,
  output logic               visible,
  output logic signed [31:0] image_u,
  output logic signed [31:0] image_v,
  output logic signed [31:0] inverse_depth
);
  import ppp_pkg::*;

  cfg_t   cfg;
  logic   f_valid, q_empty, q_full, q_pop, adv;
  entry_t f_entry, q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_ZERO: cfg.row_zero <= cfg_data;
        CFG_ROW_ONE:  cfg.row_one  <= cfg_data;
        CFG_ROW_TWO:  cfg.row_two  <= cfg_data;
        CFG_CENTER_X: cfg.center_x <= $signed(cfg_data[COORD_W-1:0]);
        CFG_CENTER_Y: cfg.center_y <= $signed(cfg_data[COORD_W-1:0]);
        CFG_CENTER_Z: cfg.center_z <= $signed(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // Front advances whenever the queue has room.
  assign adv  = ~q_full;
  assign busy = q_full;

  ppp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (start & ~busy),
    .px        (point_x),
    .py        (point_y),
    .pz        (point_z),
    .adv       (adv),
    .out_valid (f_valid),
    .out_entry (f_entry)
  );

  ppp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid & adv),
    .push_data (f_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ppp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (~q_empty),
    .in_entry      (q_head),
    .pop           (q_pop),
    .done          (done),
    .visible       (visible),
    .image_u       (image_u),
    .image_v       (image_v),
    .inverse_depth (inverse_depth)
  );

endmodule
